// File: design/slcg_pkg.sv
`timescale 1ns / 1ps

package slcg_pkg;

	// Generator constants: g' = (4096 * g + 54773) mod 714025.
	localparam int MOD_W = 20;
	localparam logic [MOD_W-1:0] LCG_MOD = 20'd714025;
	localparam logic [MOD_W-1:0] LCG_INC = 20'd54773;

	// Field widths.
	localparam int SAMPLE_W   = 20;
	localparam int FRAC_W     = 24;
	localparam int S_TDATA_W  = 32;
	localparam int M_TDATA_W  = 48;

	// The shared reducer takes two bits of its source word per cycle.
	localparam int SRC_W  = 32;
	localparam int TRY_W  = MOD_W + 2;
	localparam logic [TRY_W-1:0] MOD_X1 = TRY_W'(LCG_MOD);
	localparam logic [TRY_W-1:0] MOD_X2 = TRY_W'({LCG_MOD, 1'b0});
	localparam logic [TRY_W-1:0] MOD_X3 = MOD_X1 + MOD_X2;

	// Digit counts per job. Multiplying by 4096 is twelve zero bits shifted in.
	localparam int DIG_W       = 4;
	localparam int SEED_DIGITS = SRC_W / 2;
	localparam int IDX_DIGITS  = SRC_W / 2;
	localparam int FRAC_DIGITS = FRAC_W / 2;
	localparam int LCG_DIGITS  = 6;

	// What the reducer is loaded with.
	typedef logic [1:0] ld_kind_t;
	localparam ld_kind_t LD_SEED = 2'd0;
	localparam ld_kind_t LD_IDX  = 2'd1;
	localparam ld_kind_t LD_FRAC = 2'd2;
	localparam ld_kind_t LD_LCG  = 2'd3;

	typedef struct packed {
		logic     accept;
		logic     ld;
		ld_kind_t ld_kind;
		logic     step;
		logic     gen_from_rem;
		logic     add_commit;
		logic     held_from_sum;
		logic     held_from_ram;
		logic     ram_re;
		logic     ram_we;
		logic     we_fill;
		logic     fill_clr;
		logic     fill_inc;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic fill_last;
		logic out_ready;
	} dp_st_t;

endpackage

// File: design/slcg_ram.sv
`timescale 1ns / 1ps

module slcg_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 97
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: design/slcg_ctrl.sv
`timescale 1ns / 1ps

module slcg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              action,
	output logic              s_tready,
	output slcg_pkg::dp_cmd_t cmd,
	input  slcg_pkg::dp_st_t  st
);

	import slcg_pkg::*;

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_SEED_LD   = 4'd1;
	localparam logic [3:0] ST_SEED_RUN  = 4'd2;
	localparam logic [3:0] ST_SEED_SET  = 4'd3;
	localparam logic [3:0] ST_LCG_LD    = 4'd4;
	localparam logic [3:0] ST_LCG_RUN   = 4'd5;
	localparam logic [3:0] ST_LCG_ADD   = 4'd6;
	localparam logic [3:0] ST_IDX_LD    = 4'd7;
	localparam logic [3:0] ST_IDX_RUN   = 4'd8;
	localparam logic [3:0] ST_READ      = 4'd9;
	localparam logic [3:0] ST_READ_WAIT = 4'd10;
	localparam logic [3:0] ST_FRAC_LD   = 4'd11;
	localparam logic [3:0] ST_FRAC_RUN  = 4'd12;
	localparam logic [3:0] ST_OUT       = 4'd13;

	// Which job the generator step belongs to.
	localparam logic [1:0] PH_FILL = 2'd0;
	localparam logic [1:0] PH_HELD = 2'd1;
	localparam logic [1:0] PH_DRAW = 2'd2;

	logic [3:0]       state_q, state_d;
	logic [1:0]       phase_q, phase_d;
	logic [DIG_W-1:0] dig_q, dig_d;
	logic             seeded_q, seeded_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		phase_d  = phase_q;
		dig_d    = dig_q;
		seeded_d = seeded_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d = (action || !seeded_q) ? ST_SEED_LD : ST_IDX_LD;
				end
			end
			ST_SEED_LD: begin
				cmd.ld      = 1'b1;
				cmd.ld_kind = LD_SEED;
				dig_d       = DIG_W'(SEED_DIGITS - 1);
				state_d     = ST_SEED_RUN;
			end
			ST_SEED_RUN: begin
				cmd.step = 1'b1;
				if (dig_q == '0) begin
					state_d = ST_SEED_SET;
				end else begin
					dig_d = dig_q - 1'b1;
				end
			end
			ST_SEED_SET: begin
				cmd.gen_from_rem = 1'b1;
				cmd.fill_clr     = 1'b1;
				phase_d          = PH_FILL;
				state_d          = ST_LCG_LD;
			end
			ST_LCG_LD: begin
				cmd.ld      = 1'b1;
				cmd.ld_kind = LD_LCG;
				dig_d       = DIG_W'(LCG_DIGITS - 1);
				state_d     = ST_LCG_RUN;
			end
			ST_LCG_RUN: begin
				cmd.step = 1'b1;
				if (dig_q == '0) begin
					state_d = ST_LCG_ADD;
				end else begin
					dig_d = dig_q - 1'b1;
				end
			end
			ST_LCG_ADD: begin
				cmd.add_commit = 1'b1;
				case (phase_q)
					PH_FILL: begin
						cmd.ram_we  = 1'b1;
						cmd.we_fill = 1'b1;
						if (st.fill_last) begin
							phase_d = PH_HELD;
						end else begin
							cmd.fill_inc = 1'b1;
						end
						state_d = ST_LCG_LD;
					end
					PH_HELD: begin
						cmd.held_from_sum = 1'b1;
						seeded_d          = 1'b1;
						state_d           = ST_IDX_LD;
					end
					PH_DRAW: begin
						cmd.ram_we = 1'b1;
						state_d    = ST_FRAC_LD;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_IDX_LD: begin
				cmd.ld      = 1'b1;
				cmd.ld_kind = LD_IDX;
				dig_d       = DIG_W'(IDX_DIGITS - 1);
				state_d     = ST_IDX_RUN;
			end
			ST_IDX_RUN: begin
				cmd.step = 1'b1;
				if (dig_q == '0) begin
					state_d = ST_READ;
				end else begin
					dig_d = dig_q - 1'b1;
				end
			end
			ST_READ: begin
				cmd.ram_re = 1'b1;
				state_d    = ST_READ_WAIT;
			end
			ST_READ_WAIT: begin
				cmd.held_from_ram = 1'b1;
				phase_d           = PH_DRAW;
				state_d           = ST_LCG_LD;
			end
			ST_FRAC_LD: begin
				cmd.ld      = 1'b1;
				cmd.ld_kind = LD_FRAC;
				dig_d       = DIG_W'(FRAC_DIGITS - 1);
				state_d     = ST_FRAC_RUN;
			end
			ST_FRAC_RUN: begin
				cmd.step = 1'b1;
				if (dig_q == '0) begin
					state_d = ST_OUT;
				end else begin
					dig_d = dig_q - 1'b1;
				end
			end
			ST_OUT: begin
				if (st.out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			phase_q  <= PH_FILL;
			dig_q    <= '0;
			seeded_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			phase_q  <= phase_d;
			dig_q    <= dig_d;
			seeded_q <= seeded_d;
		end
	end

endmodule

// File: design/slcg_dp.sv
`timescale 1ns / 1ps

module slcg_dp #(
	parameter int TABLE_ENTRIES = 97
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [slcg_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [slcg_pkg::M_TDATA_W-1:0]   m_tdata,
	input  slcg_pkg::dp_cmd_t                cmd,
	output slcg_pkg::dp_st_t                 st
);

	import slcg_pkg::*;

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int PW = SAMPLE_W + $clog2(TABLE_ENTRIES + 1);

	logic [MOD_W-1:0]    gen_q;
	logic [MOD_W-1:0]    held_q;
	logic [MOD_W-1:0]    rem_q;
	logic [SRC_W-1:0]    src_q;
	logic [FRAC_W-1:0]   quo_q;
	logic [S_TDATA_W-1:0] seed_q;
	logic [AW-1:0]       addr_q;
	logic [AW-1:0]       fill_q;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] out_sample_q;
	logic [FRAC_W-1:0]   out_frac_q;

	logic [PW-1:0]       prod;
	logic [SRC_W+1:0]    seed_diff;
	logic [SRC_W+1:0]    seed_mag;
	logic [TRY_W-1:0]    trial;
	logic [1:0]          qdig;
	logic [MOD_W-1:0]    rem_next;
	logic [MOD_W:0]      inc_sum;
	logic [MOD_W-1:0]    gen_next;
	logic [AW-1:0]       rd_addr;
	logic [AW-1:0]       wr_addr;
	logic [MOD_W-1:0]    ram_rdata;

	// Index product and the seed magnitude |54773 - seed|.
	assign prod      = PW'(held_q) * PW'(TABLE_ENTRIES);
	assign seed_diff = (SRC_W + 2)'(LCG_INC) - {{2{seed_q[SRC_W-1]}}, seed_q};
	assign seed_mag  = seed_diff[SRC_W+1] ? (~seed_diff + 1'b1) : seed_diff;

	// Radix-4 reduction step: shift in two source bits, subtract 0..3 moduli.
	assign trial = {rem_q, src_q[SRC_W-1 -: 2]};
	always_comb begin
		if (trial >= MOD_X3) begin
			qdig     = 2'd3;
			rem_next = MOD_W'(trial - MOD_X3);
		end else if (trial >= MOD_X2) begin
			qdig     = 2'd2;
			rem_next = MOD_W'(trial - MOD_X2);
		end else if (trial >= MOD_X1) begin
			qdig     = 2'd1;
			rem_next = MOD_W'(trial - MOD_X1);
		end else begin
			qdig     = 2'd0;
			rem_next = MOD_W'(trial);
		end
	end

	// Adding the increment keeps the value below twice the modulus.
	assign inc_sum  = {1'b0, rem_q} + {1'b0, LCG_INC};
	assign gen_next = (inc_sum >= {1'b0, LCG_MOD}) ? MOD_W'(inc_sum - {1'b0, LCG_MOD})
	                                              : MOD_W'(inc_sum);

	// Table position is the quotient, kept in range.
	assign rd_addr = (quo_q >= FRAC_W'(TABLE_ENTRIES)) ? AW'(TABLE_ENTRIES - 1)
	                                                  : quo_q[AW-1:0];
	assign wr_addr = cmd.we_fill ? fill_q : addr_q;

	slcg_ram #(
		.WIDTH (MOD_W),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (cmd.ram_we),
		.waddr (wr_addr),
		.wdata (gen_next),
		.re    (cmd.ram_re),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			seed_q <= s_tuser ? s_tdata : S_TDATA_W'(gen_q);
		end
		if (cmd.ld) begin
			quo_q <= '0;
			case (cmd.ld_kind)
				LD_SEED: begin
					rem_q <= '0;
					src_q <= seed_mag[SRC_W-1:0];
				end
				LD_IDX: begin
					rem_q <= '0;
					src_q <= SRC_W'(prod);
				end
				LD_FRAC: begin
					rem_q <= held_q;
					src_q <= '0;
				end
				default: begin
					rem_q <= gen_q;
					src_q <= '0;
				end
			endcase
		end else if (cmd.step) begin
			rem_q <= rem_next;
			src_q <= {src_q[SRC_W-3:0], 2'b00};
			quo_q <= {quo_q[FRAC_W-3:0], qdig};
		end
		if (cmd.ram_re) begin
			addr_q <= rd_addr;
		end
		if (cmd.fill_clr) begin
			fill_q <= '0;
		end else if (cmd.fill_inc) begin
			fill_q <= fill_q + 1'b1;
		end
		if (cmd.out_load) begin
			out_sample_q <= held_q;
			out_frac_q   <= quo_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q       <= '0;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.gen_from_rem) begin
				gen_q <= rem_q;
			end else if (cmd.add_commit) begin
				gen_q <= gen_next;
			end
			if (cmd.held_from_sum) begin
				held_q <= gen_next;
			end else if (cmd.held_from_ram) begin
				held_q <= ram_rdata;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign st.fill_last = (fill_q == AW'(TABLE_ENTRIES - 1));
	assign st.out_ready = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_W'({out_frac_q, out_sample_q});

endmodule

// File: design/shuffled_lcg_uniform_generator.sv
`timescale 1ns / 1ps
// Shuffled linear congruential uniform generator.
// Input channel (s_*): one transaction per draw request. s_tuser is the action
// (0 = draw, 1 = reseed with s_tdata, then draw); s_tdata is the signed seed.
// Output channel (m_*): one transaction per request, carrying the raw sample
// (0 to 714024) and the same value as an unsigned Q0.24 fraction of 714025.
// The block works on one request at a time: s_tready is high only while the
// controller is idle. A draw's time is set by the shared radix-4 modulo unit,
// which handles two bits per cycle, in turn for the table index, for the
// generator step with its add, and for the fraction. A reseed first reduces
// the seed, then takes 98 generator steps, 97 of them written to the shuffle
// table through its one write port. The first request after reset always
// seeds, from zero unless it carries its own seed. Reset clears the
// generator, the held value and the seeded flag; the table itself is not
// cleared, since every draw follows a full fill. A finished result sits in
// the output register; while the receiver stalls the next request is still
// accepted and computed, and the controller waits with it until the output
// register frees up.
module shuffled_lcg_uniform_generator #(
	parameter int TABLE_ENTRIES = 97
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [slcg_pkg::S_TDATA_W-1:0]  s_tdata,  // [31:0] seed
	input  logic                            s_tuser,  // [0] action
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [slcg_pkg::M_TDATA_W-1:0]  m_tdata   // [19:0] sample, [43:20] unit_fraction
);

	import slcg_pkg::*;

	dp_cmd_t cmd;
	dp_st_t  st;

	// Sequencer: decides the order of seed reduction, table fill and draw.
	slcg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.action   (s_tuser),
		.s_tready (s_tready),
		.cmd      (cmd),
		.st       (st)
	);

	// Datapath: generator, held value, modulo unit, shuffle table, output register.
	slcg_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.st       (st)
	);

	// A result is never loaded over one the receiver has not yet taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("output register overwritten while stalled");

	// The table is never read and written in the same cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ram_we |-> !cmd.ram_re)
		else $error("shuffle table read and written together");

	// Only one request is in flight: acceptance drops ready at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second request accepted while busy");

	// A delivered sample is below the modulus and the padding stays zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[SAMPLE_W-1:0] < LCG_MOD)
			&& (m_tdata[M_TDATA_W-1:SAMPLE_W+FRAC_W] == '0)))
		else $error("sample out of range");

endmodule

// File: bench/tb_shuffled_lcg_uniform_generator.sv
`timescale 1ns / 1ps

module tb_shuffled_lcg_uniform_generator;

	import slcg_pkg::*;

	localparam int N_ENTRIES = 97;

	// Generator constants, kept here so the predictor stands on its own.
	localparam longint GEN_MOD = 714025;
	localparam longint GEN_MUL = 4096;
	localparam longint GEN_INC = 54773;

	// Request kinds carried on s_tuser.
	localparam logic ACT_DRAW   = 1'b0;
	localparam logic ACT_RESEED = 1'b1;

	// The limit allows for every request being a reseed, plus the longest sender
	// gap and receiver stall on each, several times over.
	localparam int CYCLE_LIMIT = 5_000_000;
	localparam int LONG_HOLD   = 300;
	localparam int TAIL_CYCLES = 60;

	typedef struct packed {
		logic        action;
		logic [31:0] seed;
	} draw_req_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic [FRAC_W-1:0]   fraction;
	} draw_res_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;

	shuffled_lcg_uniform_generator #(
		.TABLE_ENTRIES(N_ENTRIES)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Model of the generator state.
	logic [SAMPLE_W-1:0] gen_val  = '0;
	logic [SAMPLE_W-1:0] held_val = '0;
	logic [SAMPLE_W-1:0] shuf_tbl [1:N_ENTRIES];
	logic                seeded   = 1'b0;

	draw_res_t pending_draws [$];

	int err_count     = 0;
	int req_count     = 0;
	int reseed_count  = 0;
	int checked_count = 0;
	int cycle_count   = 0;

	int  burst_left = 0;
	bit  hold_req   = 1'b0;

	function automatic logic [SAMPLE_W-1:0] lcg_step(input logic [SAMPLE_W-1:0] g);
		longint t;
		t = longint'(g) * GEN_MUL + GEN_INC;
		return SAMPLE_W'(t % GEN_MOD);
	endfunction

	// Sets the generator from the seed with truncating modulo and its magnitude,
	// fills every shuffle entry, then takes one more step for the held value.
	task automatic refill_from_seed(input longint s);
		longint r;
		r = (GEN_INC - s) % GEN_MOD;
		if (r < 0) r = -r;
		gen_val = SAMPLE_W'(r);
		for (int k = 1; k <= N_ENTRIES; k++) begin
			gen_val = lcg_step(gen_val);
			shuf_tbl[k] = gen_val;
		end
		gen_val  = lcg_step(gen_val);
		held_val = gen_val;
		seeded   = 1'b1;
	endtask

	task automatic predict_draw(input logic act, input logic [31:0] sd);
		int        idx;
		draw_res_t res;
		if (act == ACT_RESEED) refill_from_seed(longint'($signed(sd)));
		else if (!seeded) refill_from_seed(longint'(gen_val));
		idx = 1 + int'((longint'(N_ENTRIES) * longint'(held_val)) / GEN_MOD);
		if (idx > N_ENTRIES) idx = N_ENTRIES;
		held_val      = shuf_tbl[idx];
		gen_val       = lcg_step(gen_val);
		shuf_tbl[idx] = gen_val;
		res.sample    = held_val;
		res.fraction  = FRAC_W'((longint'(held_val) <<< 24) / GEN_MOD);
		pending_draws.push_back(res);
	endtask

	// Both channels are watched at the rising edge. Requests feed the predictor,
	// results are matched in order against the oldest expected draw.
	always @(posedge clk) begin
		draw_res_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_draws.size() == 0) begin
					$display("%0t: unexpected result transaction, actual %h",
						$time, m_tdata);
					err_count++;
				end else begin
					want = pending_draws.pop_front();
					checked_count++;
					if (m_tdata[19:0] !== want.sample) begin
						$display("%0t: sample mismatch, expected %0d, actual %0d",
							$time, want.sample, m_tdata[19:0]);
						err_count++;
					end
					if (m_tdata[43:20] !== want.fraction) begin
						$display("%0t: unit_fraction mismatch, expected %h, actual %h",
							$time, want.fraction, m_tdata[43:20]);
						err_count++;
					end
					if (m_tdata[47:44] !== 4'h0) begin
						$display("%0t: tdata padding mismatch, expected 0, actual %h",
							$time, m_tdata[47:44]);
						err_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				req_count++;
				if (s_tuser == ACT_RESEED) reseed_count++;
				predict_draw(s_tuser, s_tdata);
			end
		end
	end

	// Receiver: the stall pattern is chosen at random from four modes. A hold request
	// forces a long stall so that the block backs up into its input.
	initial begin
		int mode;
		int hold_left;
		mode      = 0;
		hold_left = 0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if ((cycle_count % 64) == 0) mode = $urandom_range(0, 3);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = LONG_HOLD;
				m_tready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
			end else begin
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Offers one request and waits for its transaction. Called at a falling
	// edge and returns at one; ends bursts with a random gap.
	task automatic send_req(input logic act, input logic [31:0] sd);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= sd;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 50);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				s_tuser  <= 1'($urandom_range(0, 1));
				s_tdata  <= $urandom;
				repeat (gap) @(negedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// Stops offering and waits until every expected draw has come back.
	task automatic drain;
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_draws.size() != 0) @(negedge clk);
	endtask

	// Directed requests. Every draw depends on the whole shuffle table, so all
	// rows are checked by the predictor rather than by typed-in values.
	draw_req_t directed_reqs [21] = '{
		'{ACT_DRAW,   32'hDEAD_BEEF},  // first draw after reset seeds from zero
		'{ACT_DRAW,   32'h0000_0000},
		'{ACT_DRAW,   32'hFFFF_FFFF},  // seed field ignored on a draw
		'{ACT_RESEED, 32'h0000_0000},
		'{ACT_DRAW,   32'h0000_0000},
		'{ACT_RESEED, 32'h7FFF_FFFF},  // largest positive seed
		'{ACT_DRAW,   32'h1234_5678},
		'{ACT_RESEED, 32'h8000_0000},  // most negative seed
		'{ACT_RESEED, 32'hFFFF_FFFF},  // minus one
		'{ACT_RESEED, 32'd54773},      // generator starts at zero
		'{ACT_DRAW,   32'h0000_0000},
		'{ACT_RESEED, 32'd768798},     // one modulus above, zero again
		'{ACT_RESEED, 32'd768799},     // negative remainder, magnitude taken
		'{ACT_RESEED, 32'd1000000},
		'{ACT_DRAW,   32'h0000_0000},
		'{ACT_DRAW,   32'h0000_0000},
		'{ACT_DRAW,   32'h5555_5555},
		'{ACT_DRAW,   32'hAAAA_AAAA},
		'{ACT_RESEED, 32'd12345},
		'{ACT_RESEED, 32'd12345},      // same seed twice gives the same start
		'{ACT_DRAW,   32'h0000_0000}
	};

	// Watchdog.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout after %0d cycles", $time, cycle_count);
		$display("tb_shuffled_lcg_uniform_generator failed");
		$finish;
	end

	initial begin
		logic        act;
		logic [31:0] sd;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tuser  = ACT_DRAW;
		s_tdata  = '0;
		for (int k = 1; k <= N_ENTRIES; k++) shuf_tbl[k] = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(negedge clk);

		foreach (directed_reqs[i]) send_req(directed_reqs[i].action, directed_reqs[i].seed);
		drain();

		// Long output stall while requests keep coming: the block fills and
		// stops accepting until the receiver resumes.
		hold_req   = 1'b1;
		burst_left = 8;
		for (int i = 0; i < 6; i++) send_req(ACT_DRAW, $urandom);
		drain();

		for (int i = 0; i < 1500; i++) begin
			if ($urandom_range(0, 19) == 0) begin
				act = ACT_RESEED;
				case ($urandom_range(0, 5))
					0, 1: sd = $urandom;
					2: sd = $urandom_range(0, 100000);
					3: sd = -$urandom_range(0, 100000);
					4: sd = 32'(GEN_INC + longint'($urandom_range(0, 6)) * GEN_MOD
						- 3 * GEN_MOD + longint'($urandom_range(0, 4)) - 2);
					default: begin
						case ($urandom_range(0, 3))
							0: sd = 32'h8000_0000;
							1: sd = 32'h7FFF_FFFF;
							2: sd = 32'h0000_0000;
							default: sd = 32'hFFFF_FFFF;
						endcase
					end
				endcase
			end else begin
				act = ACT_DRAW;
				sd  = $urandom;
			end
			send_req(act, sd);
			if (i == 750) drain();
		end
		drain();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Covered %0d requests, %0d of them reseeds, with %0d draws checked,",
			req_count, reseed_count, checked_count);
		$display("under random sender gaps, output stalls, one long hold and drain pauses.");
		if (err_count == 0 && pending_draws.size() == 0) begin
			$display("tb_shuffled_lcg_uniform_generator passed");
		end else begin
			$display("tb_shuffled_lcg_uniform_generator failed");
		end
		$finish;
	end

endmodule
